// ===== hw/rtl/sphere_line_validator_assert.svh =====
// ----------------------------------------------------------------------------
// Sphere line validator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SPHERE_LINE_VALIDATOR_ASSERT_SVH
`define SPHERE_LINE_VALIDATOR_ASSERT_SVH

// Same-cycle implication
`define SLV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SLV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/slv_pkg.sv =====
// ----------------------------------------------------------------------------
// Sphere line validator package
// Character classes, queue sizing and the structs passed between stages.
// ----------------------------------------------------------------------------
package slv_pkg;

  // Byte classes seen by the parser
  typedef enum logic [3:0] {
    CC_SPACE,
    CC_S,
    CC_P,
    CC_COMMA,
    CC_DOT,
    CC_NEWLINE,
    CC_SIGN,
    CC_DIGIT,
    CC_OTHER
  } char_class_e;

  // Queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // One classified byte
  typedef struct packed {
    char_class_e cls;
    logic        line_end;
  } slv_item_t;

  // Front to queue
  typedef struct packed {
    logic      valid;
    slv_item_t item;
  } slv_push_t;

  // Queue head to back
  typedef struct packed {
    logic      valid;
    slv_item_t item;
  } slv_head_t;

endpackage

// ===== hw/rtl/slv_if.sv =====
// ----------------------------------------------------------------------------
// Sphere line validator channels
// Byte input channel and verdict output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface slv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_end;

  modport source (output valid, output char_code, output line_end, input ready);
  modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

interface slv_out_if;
  logic valid;
  logic ready;
  logic accepted;

  modport source (output valid, output accepted, input ready);
  modport sink   (input valid, input accepted, output ready);
endinterface

// ===== hw/rtl/slv_front.sv =====
// ----------------------------------------------------------------------------
// Sphere line validator front end
// Takes bytes from the input channel and reduces each to a character class.
// ----------------------------------------------------------------------------
module slv_front import slv_pkg::*; (
  slv_in_if.sink    item_i,
  input  logic      q_ready_i,
  output slv_push_t push_o
);

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChS       = 8'h73;
  localparam logic [7:0] ChP       = 8'h70;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;

  char_class_e cls;

  // Classify the incoming byte
  always_comb begin
    case (item_i.char_code)
      ChSpace:   cls = CC_SPACE;
      ChS:       cls = CC_S;
      ChP:       cls = CC_P;
      ChComma:   cls = CC_COMMA;
      ChDot:     cls = CC_DOT;
      ChNewline: cls = CC_NEWLINE;
      ChMinus:   cls = CC_SIGN;
      ChPlus:    cls = CC_SIGN;
      default: begin
        if (item_i.char_code >= ChZero && item_i.char_code <= ChNine) cls = CC_DIGIT;
        else cls = CC_OTHER;
      end
    endcase
  end

  // Hand off to the queue
  assign item_i.ready         = q_ready_i;
  assign push_o.valid         = item_i.valid;
  assign push_o.item.cls      = cls;
  assign push_o.item.line_end = item_i.line_end;

endmodule

// ===== hw/rtl/slv_queue.sv =====
// ----------------------------------------------------------------------------
// Sphere line validator queue
// Short FIFO of classified items between the front end and the parser.
// ----------------------------------------------------------------------------
module slv_queue import slv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  slv_push_t push_i,
  output logic      ready_o,
  output slv_head_t head_o,
  input  logic      pop_i
);

  slv_item_t              mem_q [QDepth];
  logic [QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]       cnt_q;
  logic                   do_push;
  logic                   do_pop;

  assign ready_o = (cnt_q != QCntW'(QDepth));
  assign do_push = push_i.valid && ready_o;
  assign do_pop  = pop_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.item;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        if (wr_ptr_q == QPtrW'(QDepth - 1)) wr_ptr_q <= '0;
        else wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        if (rd_ptr_q == QPtrW'(QDepth - 1)) rd_ptr_q <= '0;
        else rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/slv_back.sv =====
// ----------------------------------------------------------------------------
// Sphere line validator parser
// Runs the line automaton on classified items and registers the verdict.
// ----------------------------------------------------------------------------
`include "sphere_line_validator_assert.svh"

module slv_back import slv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  slv_head_t  head_i,
  output logic       pop_o,
  slv_out_if.source  verdict_o
);

  typedef enum logic [5:0] {
    ST_START, ST_ID1, ST_ID2, ST_SP1,
    ST_XS, ST_XB, ST_XD, ST_XA, ST_C1,
    ST_YS, ST_YB, ST_YD, ST_YA, ST_C2,
    ST_ZS, ST_ZB, ST_ZD, ST_ZA, ST_SP2,
    ST_DB, ST_DD, ST_DA, ST_SP3,
    ST_RED, ST_C3, ST_GREEN, ST_C4, ST_BLUE,
    ST_SP4, ST_RB, ST_SP5, ST_RD, ST_RA,
    ST_ACCEPT, ST_REJECT
  } state_e;

  state_e      state_q, nxt;
  char_class_e cls;
  logic        is_dig, is_sp, is_com, is_dot, is_nl, is_sgn;
  logic        out_valid_q, accepted_q;
  logic        can_out, do_pop, ends, verdict;

  assign cls    = head_i.item.cls;
  assign ends   = head_i.item.line_end;
  assign is_dig = (cls == CC_DIGIT);
  assign is_sp  = (cls == CC_SPACE);
  assign is_com = (cls == CC_COMMA);
  assign is_dot = (cls == CC_DOT);
  assign is_nl  = (cls == CC_NEWLINE);
  assign is_sgn = (cls == CC_SIGN);

  // Transition on the head item; anything unlisted rejects
  always_comb begin
    nxt = ST_REJECT;
    case (state_q)
      ST_START: begin
        if (is_sp) nxt = ST_START;
        else if (cls == CC_S) nxt = ST_ID1;
      end
      ST_ID1: if (cls == CC_P) nxt = ST_ID2;
      ST_ID2: if (is_sp) nxt = ST_SP1;
      ST_SP1: begin
        if (is_sp) nxt = ST_SP1;
        else if (is_dig) nxt = ST_XB;
        else if (is_sgn) nxt = ST_XS;
      end
      // origin x
      ST_XS: if (is_dig) nxt = ST_XB;
      ST_XB: begin
        if (is_com) nxt = ST_C1;
        else if (is_dot) nxt = ST_XD;
        else if (is_dig) nxt = ST_XB;
      end
      ST_XD: if (is_dig) nxt = ST_XA;
      ST_XA: begin
        if (is_com) nxt = ST_C1;
        else if (is_dig) nxt = ST_XA;
      end
      ST_C1: begin
        if (is_dig) nxt = ST_YB;
        else if (is_sgn) nxt = ST_YS;
      end
      // origin y
      ST_YS: if (is_dig) nxt = ST_YB;
      ST_YB: begin
        if (is_com) nxt = ST_C2;
        else if (is_dot) nxt = ST_YD;
        else if (is_dig) nxt = ST_YB;
      end
      ST_YD: if (is_dig) nxt = ST_YA;
      ST_YA: begin
        if (is_com) nxt = ST_C2;
        else if (is_dig) nxt = ST_YA;
      end
      ST_C2: begin
        if (is_dig) nxt = ST_ZB;
        else if (is_sgn) nxt = ST_ZS;
      end
      // origin z
      ST_ZS: if (is_dig) nxt = ST_ZB;
      ST_ZB: begin
        if (is_sp) nxt = ST_SP2;
        else if (is_dot) nxt = ST_ZD;
        else if (is_dig) nxt = ST_ZB;
      end
      ST_ZD: if (is_dig) nxt = ST_ZA;
      ST_ZA: begin
        if (is_sp) nxt = ST_SP2;
        else if (is_dig) nxt = ST_ZA;
      end
      // diameter
      ST_SP2: begin
        if (is_sp) nxt = ST_SP2;
        else if (is_dig) nxt = ST_DB;
      end
      ST_DB: begin
        if (is_sp) nxt = ST_SP3;
        else if (is_dot) nxt = ST_DD;
        else if (is_dig) nxt = ST_DB;
      end
      ST_DD: if (is_dig) nxt = ST_DA;
      ST_DA: begin
        if (is_sp) nxt = ST_SP3;
        else if (is_dig) nxt = ST_DA;
      end
      // colour
      ST_SP3: begin
        if (is_sp) nxt = ST_SP3;
        else if (is_dig) nxt = ST_RED;
      end
      ST_RED: begin
        if (is_com) nxt = ST_C3;
        else if (is_dig) nxt = ST_RED;
      end
      ST_C3: if (is_dig) nxt = ST_GREEN;
      ST_GREEN: begin
        if (is_com) nxt = ST_C4;
        else if (is_dig) nxt = ST_GREEN;
      end
      ST_C4: if (is_dig) nxt = ST_BLUE;
      ST_BLUE: begin
        if (is_dig) nxt = ST_BLUE;
        else if (is_nl) nxt = ST_ACCEPT;
        else if (is_sp) nxt = ST_SP4;
      end
      // optional reflectiveness
      ST_SP4: begin
        if (is_sp) nxt = ST_SP4;
        else if (is_dig) nxt = ST_RB;
        else if (is_nl) nxt = ST_ACCEPT;
      end
      ST_RB: begin
        if (is_sp) nxt = ST_SP5;
        else if (is_dot) nxt = ST_RD;
        else if (is_dig) nxt = ST_RB;
        else if (is_nl) nxt = ST_ACCEPT;
      end
      ST_SP5: begin
        if (is_sp) nxt = ST_SP5;
        else if (is_dig) nxt = ST_RB;
        else if (is_dot) nxt = ST_RD;
        else if (is_nl) nxt = ST_ACCEPT;
      end
      ST_RD: if (is_dig) nxt = ST_RA;
      ST_RA: begin
        if (is_sp) nxt = ST_SP5;
        else if (is_dig) nxt = ST_RA;
        else if (is_nl) nxt = ST_ACCEPT;
      end
      ST_ACCEPT: nxt = ST_ACCEPT;
      default:   nxt = ST_REJECT;
    endcase
  end

  // Accepting end states
  assign verdict = (nxt == ST_ACCEPT) || (nxt == ST_BLUE) || (nxt == ST_SP4) ||
                   (nxt == ST_SP5) || (nxt == ST_RB) || (nxt == ST_RA);

  // A line-end item waits only while the verdict register is occupied and not being read
  assign can_out = !out_valid_q || verdict_o.ready;
  assign do_pop  = head_i.valid && (!ends || can_out);
  assign pop_o   = do_pop;

  // State and verdict register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_START;
      out_valid_q <= 1'b0;
      accepted_q  <= 1'b0;
    end else begin
      if (do_pop) state_q <= ends ? ST_START : nxt;
      if (do_pop && ends) begin
        out_valid_q <= 1'b1;
        accepted_q  <= verdict;
      end else if (verdict_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign verdict_o.valid    = out_valid_q;
  assign verdict_o.accepted = accepted_q;

  `SLV_ASSERT_NEXT(a_line_restart, do_pop && ends, state_q == ST_START, "no restart after line end")
  `SLV_ASSERT_NEXT(a_reject_sticky, do_pop && !ends && state_q == ST_REJECT, state_q == ST_REJECT, "reject left")
  `SLV_ASSERT_NEXT(a_accept_sticky, do_pop && !ends && state_q == ST_ACCEPT, state_q == ST_ACCEPT, "accept left")
  `SLV_ASSERT_NOW(a_no_overwrite, out_valid_q && !verdict_o.ready, !(do_pop && ends), "verdict overwritten")

endmodule

// ===== hw/rtl/sphere_line_validator.sv =====
// ----------------------------------------------------------------------------
// Sphere line validator
// Checks sphere scene lines byte by byte and reports one verdict per line.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle, sustained while no verdict waits unread,
// through a front end that classifies it and a two-entry queue feeding the
// parser, whose state register advances on every popped item. The byte
// flagged as line end yields one verdict item (accepted = 1 for a valid
// line), registered in the queue and then in the verdict output register,
// whose valid it raises; it stays in that output register until read, and
// the parser restarts for the next line when that byte is popped. Other
// bytes produce no output. While a verdict waits unread, a further line-end
// byte stalls in the queue and the input stalls once the queue is full.
module sphere_line_validator import slv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  slv_in_if.sink     item_i,
  slv_out_if.source  verdict_o
);

  slv_push_t push;
  slv_head_t head;
  logic      q_ready;
  logic      pop;

  slv_front u_front (
    .item_i    (item_i),
    .q_ready_i (q_ready),
    .push_o    (push)
  );

  slv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .head_o  (head),
    .pop_i   (pop)
  );

  slv_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .pop_o     (pop),
    .verdict_o (verdict_o)
  );

endmodule

// ===== tb/tb_sphere_line_validator.sv =====
// ----------------------------------------------------------------------------
// Sphere line validator testbench
// Streams directed and random scene lines into the validator one byte per
// item, predicts each line verdict with a behavioral copy of the parse
// automaton and compares every verdict item in order. Both channels idle
// at random; the verdict side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_sphere_line_validator;
  import slv_pkg::*;

  // Parse automaton states
  typedef enum logic [5:0] {
    PS_START, PS_ID1, PS_ID2, PS_SP1,
    PS_XS, PS_XB, PS_XD, PS_XA, PS_C1,
    PS_YS, PS_YB, PS_YD, PS_YA, PS_C2,
    PS_ZS, PS_ZB, PS_ZD, PS_ZA, PS_SP2,
    PS_DB, PS_DD, PS_DA, PS_SP3,
    PS_RED, PS_C3, PS_GREEN, PS_C4, PS_BLUE,
    PS_SP4, PS_RB, PS_SP5, PS_RD, PS_RA,
    PS_ACCEPT, PS_REJECT
  } parse_state_e;

  // Bytes with a meaning to the parser
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_S     = "s";
  localparam logic [7:0] CH_P     = "p";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";

  localparam int CycleLimit  = 200000;
  localparam int SettleCycles = 20;
  localparam int RandBytes   = 1000;
  localparam int MinRandLines = 60;
  localparam int LongHoldLen = 400;
  localparam int LongHoldAt  = 20;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       drain;
  } stim_t;

  logic clk = 1'b0;
  logic rst_ni;

  slv_in_if  in_ch ();
  slv_out_if out_ch ();

  sphere_line_validator dut (
    .clk_i     (clk),
    .rst_ni    (rst_ni),
    .item_i    (in_ch),
    .verdict_o (out_ch)
  );

  always #5 clk = ~clk;

  stim_t        pending[$];
  logic  [7:0]  line_buf[$];
  bit           verdict_q[$];
  parse_state_e line_ps;
  int           err_cnt;
  int           n_verdicts;
  int           n_lines;
  int           gap_left;
  int           stall_left;
  int           hold_left;
  bit           hold_done;
  bit           drv_calm;
  bit           rcv_calm;
  int           cyc;

  // ---------------------------------------------------------------------------
  // Verdict predictor
  // ---------------------------------------------------------------------------
  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_sign(logic [7:0] c);
    return c == CH_MINUS || c == CH_PLUS;
  endfunction

  // One decimal number: sign, integer part, point, fraction, then terminator
  function automatic parse_state_e number_next(parse_state_e s, logic [7:0] c,
      parse_state_e sgn, parse_state_e ip, parse_state_e pt, parse_state_e fp,
      logic [7:0] term, parse_state_e nx);
    if (s == sgn) return is_digit(c) ? ip : PS_REJECT;
    if (s == ip) begin
      if (c == term) return nx;
      if (c == CH_DOT) return pt;
      return is_digit(c) ? ip : PS_REJECT;
    end
    if (s == pt) return is_digit(c) ? fp : PS_REJECT;
    if (c == term) return nx;
    return is_digit(c) ? fp : PS_REJECT;
  endfunction

  function automatic parse_state_e parse_next(parse_state_e s, logic [7:0] c);
    case (s)
      PS_START: begin
        if (c == CH_SPACE) return PS_START;
        return c == CH_S ? PS_ID1 : PS_REJECT;
      end
      PS_ID1: return c == CH_P ? PS_ID2 : PS_REJECT;
      PS_ID2: return c == CH_SPACE ? PS_SP1 : PS_REJECT;
      PS_SP1: begin
        if (c == CH_SPACE) return PS_SP1;
        if (is_digit(c)) return PS_XB;
        return is_sign(c) ? PS_XS : PS_REJECT;
      end
      PS_XS, PS_XB, PS_XD, PS_XA:
        return number_next(s, c, PS_XS, PS_XB, PS_XD, PS_XA, CH_COMMA, PS_C1);
      PS_C1: begin
        if (is_digit(c)) return PS_YB;
        return is_sign(c) ? PS_YS : PS_REJECT;
      end
      PS_YS, PS_YB, PS_YD, PS_YA:
        return number_next(s, c, PS_YS, PS_YB, PS_YD, PS_YA, CH_COMMA, PS_C2);
      PS_C2: begin
        if (is_digit(c)) return PS_ZB;
        return is_sign(c) ? PS_ZS : PS_REJECT;
      end
      PS_ZS, PS_ZB, PS_ZD, PS_ZA:
        return number_next(s, c, PS_ZS, PS_ZB, PS_ZD, PS_ZA, CH_SPACE, PS_SP2);
      PS_SP2: begin
        if (c == CH_SPACE) return PS_SP2;
        return is_digit(c) ? PS_DB : PS_REJECT;
      end
      // diameter carries no sign
      PS_DB, PS_DD, PS_DA:
        return number_next(s, c, PS_REJECT, PS_DB, PS_DD, PS_DA, CH_SPACE, PS_SP3);
      PS_SP3: begin
        if (c == CH_SPACE) return PS_SP3;
        return is_digit(c) ? PS_RED : PS_REJECT;
      end
      PS_RED: begin
        if (c == CH_COMMA) return PS_C3;
        return is_digit(c) ? PS_RED : PS_REJECT;
      end
      PS_C3: return is_digit(c) ? PS_GREEN : PS_REJECT;
      PS_GREEN: begin
        if (c == CH_COMMA) return PS_C4;
        return is_digit(c) ? PS_GREEN : PS_REJECT;
      end
      PS_C4: return is_digit(c) ? PS_BLUE : PS_REJECT;
      PS_BLUE: begin
        if (is_digit(c)) return PS_BLUE;
        if (c == CH_NL) return PS_ACCEPT;
        return c == CH_SPACE ? PS_SP4 : PS_REJECT;
      end
      PS_SP4: begin
        if (c == CH_SPACE) return PS_SP4;
        if (is_digit(c)) return PS_RB;
        return c == CH_NL ? PS_ACCEPT : PS_REJECT;
      end
      PS_RB: begin
        if (c == CH_SPACE) return PS_SP5;
        if (c == CH_DOT) return PS_RD;
        if (is_digit(c)) return PS_RB;
        return c == CH_NL ? PS_ACCEPT : PS_REJECT;
      end
      PS_SP5: begin
        if (c == CH_SPACE) return PS_SP5;
        if (is_digit(c)) return PS_RB;
        if (c == CH_DOT) return PS_RD;
        return c == CH_NL ? PS_ACCEPT : PS_REJECT;
      end
      PS_RD: return is_digit(c) ? PS_RA : PS_REJECT;
      PS_RA: begin
        if (c == CH_SPACE) return PS_SP5;
        if (is_digit(c)) return PS_RA;
        return c == CH_NL ? PS_ACCEPT : PS_REJECT;
      end
      PS_ACCEPT: return PS_ACCEPT;
      default: return PS_REJECT;
    endcase
  endfunction

  // Advance the line state by one taken byte; queue the verdict on line end
  task automatic track_byte(logic [7:0] c, logic last);
    parse_state_e nx;
    nx = parse_next(line_ps, c);
    if (last) begin
      verdict_q.push_back(nx inside {PS_ACCEPT, PS_BLUE, PS_SP4, PS_SP5,
                                     PS_RB, PS_RA});
      line_ps = PS_START;
    end else begin
      line_ps = nx;
    end
  endtask

  // Mostly short idles, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Line builder
  // ---------------------------------------------------------------------------
  task automatic put(logic [7:0] c);
    line_buf.push_back(c);
  endtask

  task automatic put_digits(int lo, int hi);
    repeat ($urandom_range(lo, hi)) put(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic put_spaces(int lo, int hi);
    repeat ($urandom_range(lo, hi)) put(CH_SPACE);
  endtask

  task automatic put_number(bit signed_ok, bit frac_ok);
    if (signed_ok && $urandom_range(0, 2) == 0)
      put($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
    put_digits(1, 3);
    if (frac_ok && $urandom_range(0, 1)) begin
      put(CH_DOT);
      put_digits(1, 2);
    end
  endtask

  function automatic logic [7:0] odd_byte();
    case ($urandom_range(0, 10))
      0: return CH_SPACE;
      1: return CH_S;
      2: return CH_P;
      3: return CH_COMMA;
      4: return CH_DOT;
      5: return CH_NL;
      6: return CH_MINUS;
      7: return CH_PLUS;
      8: return CH_ZERO + 8'($urandom_range(0, 9));
      9: return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Reflectiveness: one or more numbers split by spaces
  task automatic put_reflect(bit open_point);
    int n;
    n = $urandom_range(1, 2);
    put_spaces(1, 2);
    for (int i = 0; i < n; i++) begin
      if (i > 0) put_spaces(1, 2);
      put_digits(1, 2);
      if ($urandom_range(0, 2) == 0) begin
        put(CH_DOT);
        put_digits(1, 2);
      end
    end
    if (open_point) put(CH_DOT);
  endtask

  task automatic build_line();
    int pos;
    line_buf.delete();
    // raw noise
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
      return;
    end
    put_spaces(0, 2);
    put(CH_S);
    put(CH_P);
    put_spaces(1, 2);
    put_number(1, 1);
    put(CH_COMMA);
    put_number(1, 1);
    put(CH_COMMA);
    put_number(1, 1);
    put_spaces(1, 2);
    put_number(0, 1);
    put_spaces(1, 2);
    put_digits(1, 3);
    put(CH_COMMA);
    put_digits(1, 3);
    put(CH_COMMA);
    put_digits(1, 3);
    case ($urandom_range(0, 6))
      0: ;
      1: put_spaces(1, 2);
      2: put_reflect(0);
      3: put_reflect(1);
      4: begin
        put_reflect(0);
        put(CH_NL);
      end
      default: begin
        // newline, then bytes the accept state must swallow
        if ($urandom_range(0, 1)) put_spaces(1, 1);
        put(CH_NL);
        repeat ($urandom_range(0, 3)) put(odd_byte());
      end
    endcase
    // break some lines
    pos = $urandom_range(0, line_buf.size() - 1);
    case ($urandom_range(0, 9))
      0: line_buf[pos] = 8'($urandom_range(0, 255));
      1: line_buf[pos] = odd_byte();
      2: line_buf = line_buf[0:pos];
      3: line_buf.insert(pos, odd_byte());
      default: ;
    endcase
  endtask

  task automatic queue_line(bit drain);
    stim_t s;
    foreach (line_buf[i]) begin
      s.code  = line_buf[i];
      s.last  = (i == line_buf.size() - 1);
      s.drain = drain && (i == 0);
      pending.push_back(s);
    end
    n_lines++;
  endtask

  task automatic queue_text(string txt);
    line_buf.delete();
    for (int i = 0; i < txt.len(); i++) put(txt[i]);
    queue_line(0);
  endtask

  task automatic queue_byte(logic [7:0] c);
    line_buf.delete();
    put(c);
    queue_line(0);
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    stim_t nxt;
    logic  nv;
    if (!rst_ni) begin
      in_ch.valid     <= 1'b0;
      in_ch.char_code <= '0;
      in_ch.line_end  <= 1'b0;
    end else begin
      nv = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        track_byte(in_ch.char_code, in_ch.line_end);
        nv = 1'b0;
        gap_left = drv_calm ? 0 : idle_len();
        if ($urandom_range(0, 99) == 0) drv_calm = !drv_calm;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0 &&
                     !(pending[0].drain && verdict_q.size() != 0)) begin
          nxt = pending.pop_front();
          in_ch.char_code <= nxt.code;
          in_ch.line_end  <= nxt.last;
          nv = 1'b1;
        end
      end
      in_ch.valid <= nv;
    end
  end

  // ---------------------------------------------------------------------------
  // Long verdict hold-off, once, while bytes keep coming
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_verdicts >= LongHoldAt) begin
      hold_left <= LongHoldLen;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Verdict monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_verdicts++;
        if (verdict_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected verdict item: accepted=%0b", out_ch.accepted);
        end else begin
          want = verdict_q.pop_front();
          if (out_ch.accepted !== want) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("verdict %0d mismatch: accepted expected %0b got %0b",
                       n_verdicts, want, out_ch.accepted);
          end
        end
        if ($urandom_range(0, 19) == 0) rcv_calm = !rcv_calm;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!rcv_calm && $urandom_range(0, 7) == 0) begin
        stall_left = idle_len();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cyc++;
    if (cyc >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int n_rand_bytes;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.line_end  = 1'b0;
    out_ch.ready    = 1'b0;
    line_ps         = PS_START;
    err_cnt         = 0;
    n_verdicts      = 0;
    n_lines         = 0;
    gap_left        = 0;
    stall_left      = 0;
    drv_calm        = 1'b0;
    rcv_calm        = 1'b0;
    cyc             = 0;

    // directed: shortest valid line, top and bottom bytes, a bare id
    queue_text("sp 0,0,0 0 0,0,0");
    queue_byte(8'hff);
    queue_byte(8'h00);
    queue_byte(CH_SPACE);
    queue_text("sp");

    // random lines; every so often wait for the verdicts to drain first
    n_rand_bytes = 0;
    while (n_rand_bytes < RandBytes || n_lines < MinRandLines) begin
      build_line();
      n_rand_bytes += line_buf.size();
      queue_line(n_lines % 25 == 24);
    end

    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || in_ch.valid || verdict_q.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
